FILE: sv/glob_wildcard_matcher_assert.svh
// Assertion macros for the glob wildcard matcher.
// Depends on a clk and rst_n in the including scope.
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/gwm_pkg.sv
// Package for the glob wildcard matcher: sizes, command codes, wildcard bytes
// and the control struct shared by the cells. No dependencies.
package gwm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int POS_N       = PATTERN_MAX + 1;

    localparam logic [7:0] WILD_ONE = 8'h3F;
    localparam logic [7:0] WILD_ANY = 8'h2A;

    typedef enum logic [1:0] {
        CMD_PATTERN = 2'd0,
        CMD_SUBJECT = 2'd1,
        CMD_END     = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       step;
        logic       restart;
        logic [7:0] data;
    } cell_ctrl_t;

endpackage

FILE: sv/gwm_cell.sv
// One pattern position of the matcher chain: stored byte, wildcard flags and
// the raw active bit. Depends on gwm_pkg.
module gwm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                first,
    input  logic                wr_en,
    input  logic                in_use,
    input  gwm_pkg::cell_ctrl_t ctrl,
    input  logic                closed,
    input  logic                fwd_in,
    output logic                act,
    output logic                star,
    output logic                fwd_out
);
    import gwm_pkg::*;

    logic [7:0] byte_reg;
    logic       any_reg;
    logic       one_reg;
    logic       act_reg;
    logic       act_next;
    logic       hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_reg <= ctrl.data;
            any_reg  <= (ctrl.data == WILD_ANY);
            one_reg  <= (ctrl.data == WILD_ONE);
        end
    end

    assign hit = one_reg || (byte_reg == ctrl.data);

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.restart)
            act_next = first;
        else if (ctrl.step)
            act_next = (closed && any_reg && in_use) || fwd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= first;
        else
            act_reg <= act_next;
    end

    assign act     = act_reg;
    assign star    = any_reg && in_use;
    assign fwd_out = closed && in_use && !any_reg && hit;

endmodule

FILE: sv/gwm_closure.sv
// Star closure over the position set: an active position spreads upward
// through a run of stars, done as one carry chain. Depends on gwm_pkg.
module gwm_closure (
    input  logic [gwm_pkg::POS_N-1:0]       act,
    input  logic [gwm_pkg::PATTERN_MAX-1:0] star,
    output logic [gwm_pkg::POS_N-1:0]       closed
);
    import gwm_pkg::*;

    logic [POS_N-1:0] prop;
    logic [POS_N:0]   op_a;
    logic [POS_N:0]   op_b;
    logic [POS_N:0]   sum;
    logic [POS_N:0]   carry;

    // Carry into position j+1 equals closed[j]: generate = act, propagate = star below.
    assign prop  = {star, 1'b0};
    assign op_a  = {1'b0, act | prop};
    assign op_b  = {1'b0, act};
    assign sum   = op_a + op_b;
    assign carry = sum ^ op_a ^ op_b;

    assign closed = carry[POS_N:1];

endmodule

FILE: sv/glob_wildcard_matcher.sv
// Glob wildcard matcher, top level: a chain of position cells plus a star closure.
// Throughput one transfer per cycle for every command while cmd_stall is low; a result
// follows in the cycle after its end command transfer, held in an output register.
// Reset: pattern empty, overflow clear, only the start position active, no result.
// No clearing pass; the pattern bytes are undefined until written.
// Depends on gwm_pkg, gwm_cell, gwm_closure and glob_wildcard_matcher_assert.svh.
`include "glob_wildcard_matcher_assert.svh"

module glob_wildcard_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       matched,
    output logic       pattern_overflow
);
    import gwm_pkg::*;

    logic                   accept;
    cmd_t                   op;
    cell_ctrl_t             ctrl;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   full;
    logic [POS_N-1:0]       act_vec;
    logic [POS_N-1:0]       closed;
    logic [PATTERN_MAX-1:0] star_vec;
    logic [PATTERN_MAX:0]   fwd;
    logic                   res_valid_reg;
    logic                   matched_reg;
    logic                   ovf_out_reg;
    logic                   take_end;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign op        = cmd_t'(cmd);
    assign full      = (len_reg == LEN_W'(PATTERN_MAX));
    assign take_end  = accept && (op == CMD_END);

    assign ctrl.step    = accept && (op == CMD_SUBJECT);
    assign ctrl.restart = accept && ((op == CMD_END) || (op == CMD_CLEAR));
    assign ctrl.data    = data_byte;

    assign fwd[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            gwm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .first   ((gi == 0) ? 1'b1 : 1'b0),
                .wr_en   (accept && (op == CMD_PATTERN) && (len_reg == LEN_W'(gi))),
                .in_use  (LEN_W'(gi) < len_reg),
                .ctrl    (ctrl),
                .closed  (closed[gi]),
                .fwd_in  (fwd[gi]),
                .act     (act_vec[gi]),
                .star    (star_vec[gi]),
                .fwd_out (fwd[gi+1])
            );
        end
    endgenerate

    assign act_vec[PATTERN_MAX] = last_reg;

    gwm_closure u_closure (
        .act    (act_vec),
        .star   (star_vec),
        .closed (closed)
    );

    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        last_next = last_reg;
        if (accept)
        begin
            case (op)
                CMD_PATTERN:
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        len_next = len_reg + LEN_W'(1);
                end
                CMD_SUBJECT: last_next = fwd[PATTERN_MAX];
                CMD_END:     last_next = 1'b0;
                CMD_CLEAR:
                begin
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    last_next = 1'b0;
                end
                default: len_next = len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            last_reg <= last_next;
            if (take_end)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_end)
        begin
            matched_reg <= closed[len_reg];
            ovf_out_reg <= ovf_reg;
        end
    end

    assign res_valid        = res_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

    `GWM_ASSERT_NEXT(a_restart_start_only, ctrl.restart, act_vec == POS_N'(1),
        "position set not back to start after end or clear")
    `GWM_ASSERT_NOW(a_no_pos_past_len, 1'b1, (act_vec >> len_reg) <= POS_N'(1),
        "active position beyond pattern length")
    `GWM_ASSERT_NEXT(a_overflow_on_full, accept && (op == CMD_PATTERN) && full,
        ovf_reg && (len_reg == LEN_W'(PATTERN_MAX)),
        "append to full pattern did not flag overflow")
    `GWM_ASSERT_NEXT(a_end_gives_result, take_end, res_valid,
        "end command transfer did not load a result")

endmodule

FILE: verif/glob_wildcard_matcher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for glob_wildcard_matcher: drives pattern, subject, end and
// clear transfers, and checks each match report against its own position-set predictor.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL.
module glob_wildcard_matcher_tb;
    import gwm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TOTAL_ITEMS  = 1300;

    typedef struct {
        cmd_t       op;
        logic [7:0] value;
    } xfer_t;

    typedef struct packed {
        logic hit;
        logic ovf;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] cmd = CMD_PATTERN;
    logic [7:0] data_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       matched;
    logic       pattern_overflow;

    xfer_t      pending_q[$];
    verdict_t   verdict_q[$];
    logic [7:0] gen_pattern[$];

    // predictor state
    logic [7:0]       pat_mem[PATTERN_MAX];
    int               pat_len = 0;
    logic [POS_N-1:0] reach = POS_N'(1);
    logic             ovf_flag = 1'b0;

    int  xfers_queued = 0;
    int  xfers_taken = 0;
    int  reports_checked = 0;
    int  hits_seen = 0;
    int  ovf_seen = 0;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  cmd_taken = 0;
    bit  jitter_on = 1;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  holds_asked = 0;
    int  holds_begun = 0;
    int  hold_cnt = 0;
    bit  hold_on = 0;

    glob_wildcard_matcher dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void close_stars();
        for (int i = 0; i < pat_len; i++)
        begin
            if (reach[i] && pat_mem[i] == WILD_ANY)
                reach[i+1] = 1'b1;
        end
    endfunction

    function automatic void predict_transfer(cmd_t op, logic [7:0] b);
        logic [POS_N-1:0] nxt;
        case (op)
            CMD_PATTERN:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end
                else
                    ovf_flag = 1'b1;
            end
            CMD_SUBJECT:
            begin
                close_stars();
                nxt = '0;
                for (int i = 0; i < pat_len; i++)
                begin
                    if (reach[i])
                    begin
                        if (pat_mem[i] == WILD_ANY)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == WILD_ONE || pat_mem[i] == b)
                            nxt[i+1] = 1'b1;
                    end
                end
                reach = nxt;
            end
            CMD_END:
            begin
                close_stars();
                verdict_q.push_back('{hit: reach[pat_len], ovf: ovf_flag});
                reach = POS_N'(1);
            end
            default:
            begin
                pat_len = 0;
                ovf_flag = 1'b0;
                reach = POS_N'(1);
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, verdict_t exp, verdict_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                     $time, what, exp.hit, exp.ovf, got.hit, got.ovf);
    endfunction

    // monitor, predictor hookup and watchdog
    always @(posedge clk)
    begin : mon_blk
        verdict_t got;
        verdict_t exp;
        bit       busy;
        busy = 0;
        cmd_taken = 0;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                busy = 1;
                got = '{hit: matched, ovf: pattern_overflow};
                if (verdict_q.size() == 0)
                    note_mismatch("report with none pending", 'x, got);
                else
                begin
                    exp = verdict_q.pop_front();
                    reports_checked++;
                    hits_seen += got.hit;
                    ovf_seen += got.ovf;
                    if (got !== exp)
                        note_mismatch("report mismatch", exp, got);
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                busy = 1;
                cmd_taken = 1;
                xfers_taken++;
                predict_transfer(cmd_t'(cmd), data_byte);
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("glob_wildcard_matcher_tb: done, errors");
                $finish;
            end
        end
    end

    // sender
    always @(negedge clk)
    begin : drive_blk
        xfer_t nxt;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (jitter_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 3);
                cmd_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                nxt = pending_q.pop_front();
                cmd <= nxt.op;
                data_byte <= nxt.value;
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // long receiver hold
    always @(posedge clk)
    begin
        if (hold_on)
        begin
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
                hold_on = 0;
        end
        else if (holds_begun < holds_asked)
        begin
            holds_begun++;
            hold_cnt = 0;
            hold_on = 1;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_on)
            res_stall <= 1'b1;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            res_stall <= 1'b1;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            recv_gap = $urandom_range(0, 3);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    task automatic push_xfer(cmd_t op, logic [7:0] b);
        pending_q.push_back('{op: op, value: b});
        xfers_queued++;
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_pat_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61;
            3, 4:    return 8'h62;
            5, 6:    return WILD_ANY;
            7:       return WILD_ONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic append_pattern(logic [7:0] b);
        push_xfer(CMD_PATTERN, b);
        if (gen_pattern.size() < PATTERN_MAX)
            gen_pattern.push_back(b);
    endtask

    // one pattern followed by a few subjects, mostly built to match, or else a short random burst and a clear
    task automatic gen_session();
        logic [7:0] subj[$];
        int         n;
        int         k;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                push_xfer(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            gen_pattern.delete();
            push_xfer(CMD_CLEAR, 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            push_xfer(CMD_CLEAR, 8'($urandom_range(0, 255)));
            gen_pattern.delete();
        end
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 7);
        repeat (n)
            append_pattern(pick_pat_byte());
        repeat ($urandom_range(1, 4))
        begin
            subj.delete();
            foreach (gen_pattern[i])
            begin
                if (gen_pattern[i] == WILD_ANY)
                    repeat ($urandom_range(0, 3))
                        subj.push_back(letter());
                else if (gen_pattern[i] == WILD_ONE)
                    subj.push_back($urandom_range(0, 1) ? letter() : 8'($urandom_range(0, 255)));
                else
                    subj.push_back(gen_pattern[i]);
            end
            if ($urandom_range(0, 9) < 3)
            begin
                k = (subj.size() > 0) ? $urandom_range(0, subj.size() - 1) : 0;
                case ($urandom_range(0, 2))
                    0: if (subj.size() > 0) subj.delete(k);
                    1: if (subj.size() > 0) subj[k] = letter();
                    default: subj.insert(k, letter());
                endcase
            end
            foreach (subj[i])
            begin
                push_xfer(CMD_SUBJECT, subj[i]);
                if ($urandom_range(0, 39) == 0)
                    append_pattern(pick_pat_byte());
            end
            push_xfer(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (xfers_taken != xfers_queued || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty vs empty, star vs empty, extreme bytes, wildcard one,
        // mismatch, pattern grown mid-subject
        push_xfer(CMD_END, 8'hFF);
        push_xfer(CMD_PATTERN, WILD_ANY);
        push_xfer(CMD_END, 8'h00);
        push_xfer(CMD_CLEAR, 8'hFF);
        push_xfer(CMD_PATTERN, WILD_ONE);
        push_xfer(CMD_PATTERN, 8'h00);
        push_xfer(CMD_PATTERN, 8'hFF);
        push_xfer(CMD_SUBJECT, 8'hAB);
        push_xfer(CMD_SUBJECT, 8'h00);
        push_xfer(CMD_SUBJECT, 8'hFF);
        push_xfer(CMD_END, 8'h55);
        push_xfer(CMD_SUBJECT, 8'h00);
        push_xfer(CMD_END, 8'hAA);
        push_xfer(CMD_CLEAR, 8'h00);
        push_xfer(CMD_PATTERN, 8'h61);
        push_xfer(CMD_SUBJECT, 8'h61);
        push_xfer(CMD_PATTERN, 8'h62);
        push_xfer(CMD_SUBJECT, 8'h62);
        push_xfer(CMD_END, 8'h00);
        push_xfer(CMD_CLEAR, 8'h00);
        push_xfer(CMD_END, 8'h00);
        wait_drained();

        // back-pressure: receiver holds off while end transfers keep coming
        holds_asked = 1;
        push_xfer(CMD_CLEAR, 8'h00);
        push_xfer(CMD_PATTERN, WILD_ANY);
        push_xfer(CMD_PATTERN, 8'h61);
        repeat (20)
        begin
            push_xfer(CMD_SUBJECT, letter());
            push_xfer(CMD_END, 8'($urandom_range(0, 255)));
        end
        wait_drained();

        gen_pattern.delete();
        push_xfer(CMD_CLEAR, 8'h00);
        while (xfers_queued < RANDOM_ITEMS)
        begin
            gen_session();
            if (pending_q.size() > 200)
                while (pending_q.size() >= 50)
                    @(posedge clk);
        end
        wait_drained();

        jitter_on = 0;
        while (xfers_queued < TOTAL_ITEMS)
            gen_session();
        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d transfers and %0d match reports (%0d hits, %0d with overflow),",
                 xfers_taken, reports_checked, hits_seen, ovf_seen);
        $display("with random idling, one long output hold and %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("glob_wildcard_matcher_tb: done, clean");
        else
            $display("glob_wildcard_matcher_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/gwm_pkg.sv
sv/gwm_cell.sv
sv/gwm_closure.sv
sv/glob_wildcard_matcher.sv
verif/glob_wildcard_matcher_tb.sv
